// File: rtl/address_access_counter_table_top_assert.svh
// Assertion macros for the address access counter table.
// Used by address_access_counter_table_top; depends on nothing else.
`ifndef ADDRESS_ACCESS_COUNTER_TABLE_TOP_ASSERT_SVH
`define ADDRESS_ACCESS_COUNTER_TABLE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AACT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AACT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/aact_pkg.sv
// Types and constants shared by the address access counter table.
// Used by aact_cell and address_access_counter_table_top; no dependencies.
package aact_pkg;

   localparam int unsigned ADDR_W  = 32;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned COUNT_W = 32;
   localparam int unsigned SLOT_W  = 5;
   localparam int unsigned USED_W  = 6;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic {
      OP_RECORD = 1'b0,
      OP_READ   = 1'b1
   } op_type;

   typedef struct packed {
      logic                valid;
      op_type              op;
      logic [ADDR_W-1:0]   address;
      logic [VALUE_W-1:0]  data_value;
      logic [SLOT_W-1:0]   read_index;
      logic                done;
      logic                entry_found;
      logic [SLOT_W-1:0]   slot;
      logic [ADDR_W-1:0]   entry_address;
      logic [COUNT_W-1:0]  access_count;
      logic [VALUE_W-1:0]  last_value;
      logic                dropped;
   } token_type;

endpackage

// File: rtl/aact_cell.sv
// One table entry of the address access counter table and its token stage.
// Depends on aact_pkg.
module aact_cell #(
   parameter int CELL_ID = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  aact_pkg::token_type token_in,
   input  logic                used,
   output aact_pkg::token_type token_out,
   output logic                fill
);
   import aact_pkg::*;

   localparam logic [8:0] ID_BITS = 9'(CELL_ID);

   logic [ADDR_W-1:0]  address_ff, address_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [VALUE_W-1:0] last_ff, last_in;
   logic               write_en;
   token_type          token_ff, token_in_next;

   always_comb begin
      token_in_next = token_in;
      address_in    = token_in.address;
      count_in      = count_ff;
      last_in       = token_in.data_value;
      write_en      = 1'b0;
      fill          = 1'b0;
      if (token_in.valid && !token_in.done) begin
         case (token_in.op)
            OP_READ: begin
               if ({4'b0, token_in.read_index} == ID_BITS) begin
                  token_in_next.done = 1'b1;
                  if (used) begin
                     token_in_next.entry_found   = 1'b1;
                     token_in_next.entry_address = address_ff;
                     token_in_next.access_count  = count_ff;
                     token_in_next.last_value    = last_ff;
                  end
               end
            end
            OP_RECORD: begin
               if (used && address_ff == token_in.address) begin
                  address_in = address_ff;
                  count_in   = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_W'(1);
                  write_en   = 1'b1;
                  token_in_next.entry_found = 1'b1;
               end else if (!used) begin
                  count_in = COUNT_W'(1);
                  write_en = 1'b1;
                  fill     = 1'b1;
               end
               if (write_en) begin
                  token_in_next.done          = 1'b1;
                  token_in_next.dropped       = 1'b0;
                  token_in_next.slot          = ID_BITS[SLOT_W-1:0];
                  token_in_next.entry_address = address_in;
                  token_in_next.access_count  = count_in;
                  token_in_next.last_value    = last_in;
               end
            end
            default: begin
               token_in_next = token_in;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= '0;
      end else begin
         token_ff <= token_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         address_ff <= address_in;
         count_ff   <= count_in;
         last_ff    <= last_in;
      end
   end

   assign token_out = token_ff;

endmodule

// File: rtl/address_access_counter_table_top.sv
// Address access counter table: a bus access profiler built as a row of entry cells.
// Request words enter on req_, result words leave on rsp_ (one result per request).
// A request word carries req_tuser = op (0 records an access, 1 reads an entry).
// A record looks for a used entry holding the address; on a hit the count goes up
// by one, saturating at all ones, and the last value is replaced. On a miss the
// first free entry is filled with count 1; with no free entry the access is dropped.
// A read returns the entry at read_index, or not-found with zeros above the fill level.
// The request passes one cell per cycle along the row of ENTRIES cells and then loads
// the output register. One request is in flight at a time: a new request is accepted
// only once the result of the last one has been taken, and the length of the cell row
// sets the time between requests. When the receiver stalls, the result holds in the
// output register and req_tready stays low until it is taken. Reset empties the table
// (fill level zero) and drops any request in flight, with no clearing pass.
// Depends on aact_pkg, aact_cell and address_access_counter_table_top_assert.svh.
`include "address_access_counter_table_top_assert.svh"

module address_access_counter_table_top #(
   parameter int ENTRIES = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // req_tdata: address [31:0], data_value [63:32], read_index [68:64], zeros above.
   input  logic [71:0]  req_tdata,
   // req_tuser: op [0].
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // rsp_tdata: entry_found [0], slot [5:1], entry_address [37:6], access_count [69:38],
   // last_value [101:70], dropped [102], entries_used [108:103], zeros above.
   output logic [111:0] rsp_tdata
);
   import aact_pkg::*;

   localparam int FILL_W = $clog2(ENTRIES + 1);

   aact_pkg::token_type  tok [0:ENTRIES];
   token_type            head_tok;
   logic [ENTRIES-1:0]   used_vec;
   logic [ENTRIES-1:0]   fill_vec;
   logic [ENTRIES-1:0]   cell_valid;
   logic [FILL_W-1:0]    fill_level_ff, fill_level_in;
   logic                 busy_ff, busy_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [111:0]         rsp_tdata_ff;
   logic                 req_accept;
   logic                 rsp_accept;
   token_type            last_tok;

   assign req_tready = !busy_ff;
   assign req_accept = req_tvalid && !busy_ff;
   assign rsp_accept = rsp_tvalid_ff && rsp_tready;

   always_comb begin
      head_tok            = '0;
      head_tok.valid      = req_accept;
      head_tok.op         = op_type'(req_tuser);
      head_tok.address    = req_tdata[31:0];
      head_tok.data_value = req_tdata[63:32];
      head_tok.read_index = req_tdata[68:64];
      if (op_type'(req_tuser) == OP_READ) begin
         head_tok.slot = req_tdata[68:64];
      end else begin
         head_tok.dropped = 1'b1;
      end
   end

   assign tok[0] = head_tok;

   for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
      assign used_vec[k]   = fill_level_ff > FILL_W'(k);
      assign cell_valid[k] = tok[k+1].valid;
      aact_cell #(
         .CELL_ID (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .token_in  (tok[k]),
         .used      (used_vec[k]),
         .token_out (tok[k+1]),
         .fill      (fill_vec[k])
      );
   end

   assign last_tok = tok[ENTRIES];

   always_comb begin
      fill_level_in = fill_level_ff;
      if (|fill_vec) begin
         fill_level_in = fill_level_ff + FILL_W'(1);
      end
      busy_in = busy_ff;
      if (req_accept) begin
         busy_in = 1'b1;
      end else if (rsp_accept) begin
         busy_in = 1'b0;
      end
      rsp_tvalid_in = rsp_tvalid_ff;
      if (last_tok.valid) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_accept) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_level_ff <= '0;
         busy_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         fill_level_ff <= fill_level_in;
         busy_ff       <= busy_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (last_tok.valid) begin
         rsp_tdata_ff <= {3'b0, USED_W'(fill_level_ff), last_tok.dropped,
                          last_tok.last_value, last_tok.access_count,
                          last_tok.entry_address, last_tok.slot, last_tok.entry_found};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   `AACT_ASSERT_SAME(a_fill_range, clock, reset, 1'b1, fill_level_ff <= FILL_W'(ENTRIES), "fill level above table size")
   `AACT_ASSERT_SAME(a_one_in_flight, clock, reset, 1'b1, $onehot0({cell_valid, rsp_tvalid_ff}), "more than one request in flight")
   `AACT_ASSERT_NEXT(a_fill_step, clock, reset, 1'b1, (fill_level_ff == $past(fill_level_ff)) || (fill_level_ff == $past(fill_level_ff) + FILL_W'(1)), "fill level moved by more than one")
   `AACT_ASSERT_SAME(a_busy_cover, clock, reset, |cell_valid || rsp_tvalid_ff, busy_ff, "request in flight while idle")

endmodule
